// ----- rtl/lpr_pkg.sv -----
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types, constants, microcode table and CRC step for the
// length-prefixed packet receiver.
// ----------------------------------------------------------------------------
package lpr_pkg;

	localparam int BUFFER_BYTES_DEF = 64;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// reply_type codes
	localparam logic [1:0] RT_ARM    = 2'd0;
	localparam logic [1:0] RT_ITEM   = 2'd1;
	localparam logic [1:0] RT_REJECT = 2'd2;

	localparam int PC_W = 5;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_CRC_INIT,
		OP_READ,
		OP_CRC_UPD,
		OP_CMP_HI,
		OP_GOOD,
		OP_EMIT_BYTE,
		OP_EMIT_EMPTY,
		OP_REJECT,
		OP_ARM,
		OP_GO_IDLE,
		OP_SET_LEN,
		OP_STORE
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_IS_ARM,
		C_NOT_RECV,
		C_LEN_ZERO,
		C_CNT_LT_LEN,
		C_IDX_EQ_N,
		C_CRC_BAD,
		C_N_ZERO,
		C_NOT_LAST,
		C_BAD_LEN
	} cond_t;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [PC_W-1:0]  target;
		logic             fin;
	} uword_t;

	// sequencer -> datapath
	typedef struct packed {
		logic load;
		logic act;
		op_t  op;
	} ctl_t;

	// datapath -> sequencer
	typedef struct packed {
		logic is_arm;
		logic not_recv;
		logic len_zero;
		logic cnt_lt_len;
		logic idx_eq_n;
		logic crc_bad;
		logic n_zero;
		logic not_last;
		logic bad_len;
	} flags_t;

	// program entry points
	localparam logic [PC_W-1:0] PC_CRC_LOOP  = 5'd5;
	localparam logic [PC_W-1:0] PC_CRC_DONE  = 5'd7;
	localparam logic [PC_W-1:0] PC_EMIT_LOOP = 5'd11;
	localparam logic [PC_W-1:0] PC_EMPTY     = 5'd13;
	localparam logic [PC_W-1:0] PC_REJECT    = 5'd14;
	localparam logic [PC_W-1:0] PC_ARM       = 5'd15;
	localparam logic [PC_W-1:0] PC_GO_IDLE   = 5'd16;
	localparam logic [PC_W-1:0] PC_LEN_BYTE  = 5'd17;
	localparam logic [PC_W-1:0] PC_STORE     = 5'd19;
	localparam logic [PC_W-1:0] PC_NONE      = 5'd0;
	localparam int              PROG_LEN     = 20;

	function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			5'd0:  w = '{OP_NOP,        C_IS_ARM,     PC_ARM,       1'b0};
			5'd1:  w = '{OP_NOP,        C_NOT_RECV,   PC_GO_IDLE,   1'b0};
			5'd2:  w = '{OP_NOP,        C_LEN_ZERO,   PC_LEN_BYTE,  1'b0};
			5'd3:  w = '{OP_NOP,        C_CNT_LT_LEN, PC_STORE,     1'b0};
			5'd4:  w = '{OP_CRC_INIT,   C_NEVER,      PC_NONE,      1'b0};
			5'd5:  w = '{OP_READ,       C_IDX_EQ_N,   PC_CRC_DONE,  1'b0};
			5'd6:  w = '{OP_CRC_UPD,    C_ALWAYS,     PC_CRC_LOOP,  1'b0};
			5'd7:  w = '{OP_CMP_HI,     C_NEVER,      PC_NONE,      1'b0};
			5'd8:  w = '{OP_READ,       C_NEVER,      PC_NONE,      1'b0};
			5'd9:  w = '{OP_NOP,        C_CRC_BAD,    PC_REJECT,    1'b0};
			5'd10: w = '{OP_GOOD,       C_N_ZERO,     PC_EMPTY,     1'b0};
			5'd11: w = '{OP_READ,       C_NEVER,      PC_NONE,      1'b0};
			5'd12: w = '{OP_EMIT_BYTE,  C_NOT_LAST,   PC_EMIT_LOOP, 1'b1};
			5'd13: w = '{OP_EMIT_EMPTY, C_NEVER,      PC_NONE,      1'b1};
			5'd14: w = '{OP_REJECT,     C_NEVER,      PC_NONE,      1'b1};
			5'd15: w = '{OP_ARM,        C_NEVER,      PC_NONE,      1'b1};
			5'd16: w = '{OP_GO_IDLE,    C_NEVER,      PC_NONE,      1'b1};
			5'd17: w = '{OP_NOP,        C_BAD_LEN,    PC_REJECT,    1'b0};
			5'd18: w = '{OP_SET_LEN,    C_NEVER,      PC_NONE,      1'b1};
			5'd19: w = '{OP_STORE,      C_NEVER,      PC_NONE,      1'b1};
			default: w = '{OP_NOP,      C_NEVER,      PC_NONE,      1'b1};
		endcase
		return w;
	endfunction

	// One byte of the reflected CRC-16, eight shift steps.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- rtl/lpr_sequencer.sv -----
// ----------------------------------------------------------------------------
// lpr_sequencer
// Step counter and conditional jump logic over the microcode table.
// ----------------------------------------------------------------------------
module lpr_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lpr_pkg::flags_t   flags,
	output logic              busy,
	output lpr_pkg::ctl_t     ctl
);

	logic                     running_q;
	logic [lpr_pkg::PC_W-1:0] pc_q;
	lpr_pkg::uword_t          word;
	logic                     take;
	logic                     load;

	assign word = lpr_pkg::ucode_rom(pc_q);
	assign load = start && !running_q;
	assign busy = running_q;

	always_comb begin
		unique case (word.cond)
			lpr_pkg::C_NEVER:      take = 1'b0;
			lpr_pkg::C_ALWAYS:     take = 1'b1;
			lpr_pkg::C_IS_ARM:     take = flags.is_arm;
			lpr_pkg::C_NOT_RECV:   take = flags.not_recv;
			lpr_pkg::C_LEN_ZERO:   take = flags.len_zero;
			lpr_pkg::C_CNT_LT_LEN: take = flags.cnt_lt_len;
			lpr_pkg::C_IDX_EQ_N:   take = flags.idx_eq_n;
			lpr_pkg::C_CRC_BAD:    take = flags.crc_bad;
			lpr_pkg::C_N_ZERO:     take = flags.n_zero;
			lpr_pkg::C_NOT_LAST:   take = flags.not_last;
			lpr_pkg::C_BAD_LEN:    take = flags.bad_len;
			default:               take = 1'b0;
		endcase
	end

	assign ctl.load = load;
	assign ctl.act  = running_q;
	assign ctl.op   = word.op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			pc_q      <= '0;
		end else if (load) begin
			running_q <= 1'b1;
			pc_q      <= '0;
		end else if (running_q) begin
			if (take) begin
				pc_q <= word.target;
			end else if (word.fin) begin
				running_q <= 1'b0;
				pc_q      <= '0;
			end else begin
				pc_q <= lpr_pkg::PC_W'(pc_q + 1'b1);
			end
		end
	end

	a_load_runs: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> running_q)
		else $error("accepted request did not start the program");

	a_pc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> (pc_q < lpr_pkg::PC_W'(lpr_pkg::PROG_LEN)))
		else $error("step counter left the program");

	a_idle_pc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> (pc_q == '0))
		else $error("step counter not parked while idle");

endmodule

// ----- rtl/lpr_datapath.sv -----
// ----------------------------------------------------------------------------
// lpr_datapath
// Frame store, counters, CRC register and result register, driven by the
// current control word.
// ----------------------------------------------------------------------------
module lpr_datapath #(
	parameter int BUFFER_BYTES = lpr_pkg::BUFFER_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lpr_pkg::ctl_t    ctl,
	input  logic             kind,
	input  logic [7:0]       rx_byte,
	input  logic             cfg_we,
	input  logic             cfg_data,
	output lpr_pkg::flags_t  flags,
	output logic             strobe,
	output logic [1:0]       reply_type,
	output logic             arm_status,
	output logic [7:0]       payload_byte,
	output logic             byte_valid,
	output logic             last_item,
	output logic [5:0]       payload_length
);

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int CW = $clog2(BUFFER_BYTES + 1);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_RECV,
		MODE_HOLD
	} mode_t;

	mode_t           mode_q;
	logic            keep_q;
	logic            kind_q;
	logic [7:0]      byte_q;
	logic [CW-1:0]   len_q;
	logic [CW-1:0]   cnt_q;
	logic [AW-1:0]   idx_q;
	logic [AW-1:0]   plen_q;
	logic [15:0]     crc_q;
	logic            hi_ok_q;
	logic [7:0]      rdata_q;
	logic [7:0]      mem [BUFFER_BYTES];

	logic            strobe_q;
	logic [1:0]      rtype_q;
	logic            astat_q;
	logic [7:0]      pbyte_q;
	logic            bval_q;
	logic            last_q;
	logic [5:0]      plen_out_q;

	logic [CW-1:0]   len_m2;
	logic [AW-1:0]   idx_inc;
	logic            do_op;

	assign len_m2  = CW'(len_q - CW'(2));
	assign idx_inc = AW'(idx_q + 1'b1);
	assign do_op   = ctl.act;

	assign flags.is_arm     = kind_q;
	assign flags.not_recv   = (mode_q != MODE_RECV);
	assign flags.len_zero   = (len_q == '0);
	assign flags.cnt_lt_len = (cnt_q < len_q);
	assign flags.idx_eq_n   = (idx_q == plen_q);
	assign flags.crc_bad    = !(hi_ok_q && (rdata_q == crc_q[7:0]));
	assign flags.n_zero     = (plen_q == '0);
	assign flags.not_last   = (idx_inc != plen_q);
	assign flags.bad_len    = (byte_q < 8'd2) || (byte_q > 8'(BUFFER_BYTES));

	// frame store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (do_op && ctl.op == lpr_pkg::OP_STORE) begin
			mem[cnt_q[AW-1:0]] <= byte_q;
		end
		if (do_op && ctl.op == lpr_pkg::OP_READ) begin
			rdata_q <= mem[idx_q];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			keep_q   <= 1'b0;
			len_q    <= '0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) begin
				keep_q <= cfg_data;
			end
			if (do_op) begin
				unique case (ctl.op)
					lpr_pkg::OP_ARM: begin
						strobe_q <= 1'b1;
						if (mode_q != MODE_RECV) begin
							mode_q <= MODE_RECV;
							len_q  <= '0;
							cnt_q  <= '0;
						end
					end
					lpr_pkg::OP_GO_IDLE: begin
						mode_q <= MODE_IDLE;
						cnt_q  <= '0;
					end
					lpr_pkg::OP_SET_LEN: begin
						len_q <= CW'(byte_q);
						cnt_q <= '0;
					end
					lpr_pkg::OP_STORE: begin
						cnt_q <= CW'(cnt_q + 1'b1);
					end
					lpr_pkg::OP_REJECT: begin
						strobe_q <= 1'b1;
						len_q    <= '0;
						cnt_q    <= '0;
						mode_q   <= keep_q ? MODE_RECV : MODE_IDLE;
					end
					lpr_pkg::OP_GOOD: begin
						mode_q <= MODE_HOLD;
						len_q  <= '0;
						cnt_q  <= '0;
					end
					lpr_pkg::OP_EMIT_BYTE, lpr_pkg::OP_EMIT_EMPTY: begin
						strobe_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// working registers and result payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			kind_q <= kind;
			byte_q <= rx_byte;
		end
		if (do_op) begin
			unique case (ctl.op)
				lpr_pkg::OP_CRC_INIT: begin
					crc_q  <= lpr_pkg::CRC_INIT;
					idx_q  <= '0;
					plen_q <= len_m2[AW-1:0];
				end
				lpr_pkg::OP_CRC_UPD: begin
					crc_q <= lpr_pkg::crc_byte(crc_q, rdata_q);
					idx_q <= idx_inc;
				end
				lpr_pkg::OP_CMP_HI: begin
					hi_ok_q <= (rdata_q == crc_q[15:8]);
					idx_q   <= idx_inc;
				end
				lpr_pkg::OP_GOOD: begin
					idx_q <= '0;
				end
				lpr_pkg::OP_EMIT_BYTE: begin
					rtype_q    <= lpr_pkg::RT_ITEM;
					astat_q    <= 1'b0;
					pbyte_q    <= rdata_q;
					bval_q     <= 1'b1;
					last_q     <= !flags.not_last;
					plen_out_q <= 6'(plen_q);
					idx_q      <= idx_inc;
				end
				lpr_pkg::OP_EMIT_EMPTY: begin
					rtype_q    <= lpr_pkg::RT_ITEM;
					astat_q    <= 1'b0;
					pbyte_q    <= 8'h00;
					bval_q     <= 1'b0;
					last_q     <= 1'b1;
					plen_out_q <= 6'd0;
				end
				lpr_pkg::OP_REJECT: begin
					rtype_q    <= lpr_pkg::RT_REJECT;
					astat_q    <= 1'b0;
					pbyte_q    <= 8'h00;
					bval_q     <= 1'b0;
					last_q     <= 1'b1;
					plen_out_q <= 6'd0;
				end
				lpr_pkg::OP_ARM: begin
					rtype_q    <= lpr_pkg::RT_ARM;
					astat_q    <= (mode_q == MODE_RECV);
					pbyte_q    <= 8'h00;
					bval_q     <= 1'b0;
					last_q     <= 1'b0;
					plen_out_q <= 6'd0;
				end
				default: begin
				end
			endcase
		end
	end

	assign strobe         = strobe_q;
	assign reply_type     = rtype_q;
	assign arm_status     = astat_q;
	assign payload_byte   = pbyte_q;
	assign byte_valid     = bval_q;
	assign last_item      = last_q;
	assign payload_length = plen_out_q;

	a_store_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(do_op && ctl.op == lpr_pkg::OP_STORE) |-> (cnt_q < len_q && mode_q == MODE_RECV))
		else $error("store outside the current frame");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(do_op && ctl.op == lpr_pkg::OP_EMIT_BYTE) |-> (idx_q < plen_q))
		else $error("payload emission past the packet end");

	a_len_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CW'(BUFFER_BYTES))
		else $error("frame length above buffer size");

endmodule

// ----- rtl/length_prefixed_packet_receiver_crc16_top.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_packet_receiver_crc16_top
// Receives length-prefixed radio frames, checks a reflected CRC-16 and
// replays the payload of good frames.
// ----------------------------------------------------------------------------
// Usage:
//  - Issue a request by raising start with kind/rx_byte while busy is low;
//    kind 1 arms reception, kind 0 delivers one received byte.
//  - Once armed, the first byte is the frame length (payload plus two CRC
//    bytes), the next bytes are stored, and the byte after them runs the
//    check. A good frame yields one result per payload byte, the last one
//    flagged, or one empty result if none; a bad frame or length, one reject.
//  - Results appear on the result ports for one cycle with strobe high; the
//    receiver cannot hold them off, so take each one as it comes.
//  - keep_listening is written through cfg_valid/cfg_ready/cfg_data while
//    the block is idle; cfg_ready is low while busy.
// Timing: a microcoded step counter walks a 20-word program, one word per
//  cycle, over a frame store with one write port and one registered read
//  port. Busy rises the cycle after the request. The check byte reads each
//  payload byte and folds it into the CRC, compares the two CRC bytes, then
//  reads and emits each payload byte of a good frame; every read step comes
//  before the step that uses it, as the frame store read is registered.
//  A result strobes in the cycle after the step that makes it.
// Reset: arst_n clears mode to idle, the frame length and stored-byte count
//  to zero, strobe and keep_listening to 0; the frame store needs no clearing.
// ----------------------------------------------------------------------------
module length_prefixed_packet_receiver_crc16_top #(
	parameter int BUFFER_BYTES = lpr_pkg::BUFFER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [7:0]  rx_byte,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	// result channel
	output logic        strobe,
	output logic [1:0]  reply_type,
	output logic        arm_status,
	output logic [7:0]  payload_byte,
	output logic        byte_valid,
	output logic        last_item,
	output logic [5:0]  payload_length
);

	lpr_pkg::ctl_t   ctl;
	lpr_pkg::flags_t flags;

	// hold off configuration while a request runs
	assign cfg_ready = !busy;

	lpr_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.busy   (busy),
		.ctl    (ctl)
	);

	lpr_datapath #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.kind           (kind),
		.rx_byte        (rx_byte),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_data       (cfg_data),
		.flags          (flags),
		.strobe         (strobe),
		.reply_type     (reply_type),
		.arm_status     (arm_status),
		.payload_byte   (payload_byte),
		.byte_valid     (byte_valid),
		.last_item      (last_item),
		.payload_length (payload_length)
	);

endmodule
